// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker. Each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ILHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ILHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ilha_pkg.sv =====
package ilha_pkg;

  // Default sizing
  localparam int HEAP_BYTES_DEF = 4096;
  localparam int GRANULES_DEF   = 512;

  // Arena layout
  localparam int HDR_BYTES  = 4;
  localparam int GRAN_BYTES = 8;
  localparam int GRAN_SHIFT = $clog2(GRAN_BYTES);

  // Field widths
  localparam int REQ_W    = 2;
  localparam int BYTES_W  = 12;
  localparam int OFF_W    = 12;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = 12;
  localparam int ARENA_W  = 12;
  localparam int NEED_W   = BYTES_W + 1 - GRAN_SHIFT;
  localparam int TGT_W    = OFF_W - GRAN_SHIFT;

  localparam logic [ARENA_W-1:0]    ARENA_RESET = 12'd4092;
  localparam logic [GRAN_SHIFT-1:0] PAYLOAD_OFS = 3'b100;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COAL  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [BYTES_W-1:0] alloc_bytes;
    logic [OFF_W-1:0]   payload_offset;
  } ilha_item_t;

  typedef struct packed {
    logic init;      // rebuild the arena header
    logic out_free;  // result register can take a word
  } ilha_ctl_t;

  typedef struct packed {
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   address;
  } ilha_res_t;

  // Granules for a byte count plus header, rounded up
  function automatic logic [NEED_W-1:0] granules_for(input logic [BYTES_W-1:0] b);
    logic [BYTES_W:0] s;
    s = {1'b0, b} + (BYTES_W+1)'(HDR_BYTES + GRAN_BYTES - 1);
    return s[BYTES_W:GRAN_SHIFT];
  endfunction

endpackage

// ===== design/ilha_ifs.sv =====
interface ilha_req_if;
  import ilha_pkg::*;
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [BYTES_W-1:0] alloc_bytes;
  logic [OFF_W-1:0]   payload_offset;
  modport source (output valid, req_type, alloc_bytes, payload_offset, input ready);
  modport sink (input valid, req_type, alloc_bytes, payload_offset, output ready);
endinterface

interface ilha_rsp_if;
  import ilha_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   address;
  modport source (output valid, status, address, input ready);
  modport sink (input valid, status, address, output ready);
endinterface

// ===== design/implicit_list_heap_allocator.sv =====
// First-fit heap allocator over an arena of 8-byte granules kept as an implicit
// list: every block begins with a header (size in granules, allocated mark) in
// a header RAM of GRANULES entries, and the walk goes from block to block.
// Requests: allocate (payload bytes + 4-byte header, rounded up to a granule),
// free (by payload offset) and coalesce (merge neighbouring free blocks). One
// request word is in flight at a time; req.ready is low while it is worked on.
// The header walk does one header read (S_RD) and one add (S_EVAL) per
// visited block, so an allocate or a free keeps req.ready low longer the
// more blocks it passes, and a coalesce the more neighbours it examines.
// A malformed free or an unused request code goes straight to S_FIN. A
// word stays in S_FIN until the output register can take it; the next word
// can be taken the cycle after.
// The result is held in an output register, so a finished word may wait on
// rsp while the next request runs.
// A write to the arena size register forgets every allocation and rebuilds the
// arena as one free block; this, and the same step after reset, writes only the
// first header (stale entries are never reached).
module implicit_list_heap_allocator #(
  parameter int HEAP_BYTES = ilha_pkg::HEAP_BYTES_DEF,
  parameter int GRANULES   = ilha_pkg::GRANULES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  ilha_req_if.sink                     req,
  ilha_rsp_if.source                   rsp,
  input  logic                         cfg_we,
  input  logic [ilha_pkg::ARENA_W-1:0] cfg_wdata
);
  import ilha_pkg::*;

  localparam int SZ_W = $clog2(GRANULES+1);
  // granule cap: whichever is smaller, header RAM depth or heap size
  localparam int CAP  = (HEAP_BYTES / GRAN_BYTES < GRANULES) ?
                        HEAP_BYTES / GRAN_BYTES : GRANULES;
  localparam int GW   = ((SZ_W > NEED_W) ? SZ_W : NEED_W) + 1;

  logic [ARENA_W-1:0]  arena_src;
  logic [NEED_W-1:0]   gran_raw;
  logic [SZ_W-1:0]     arena_granules, arena_granules_next;

  ilha_ctl_t           ctl;
  ilha_res_t           res;
  ilha_item_t          item;
  logic                seq_ready;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0]   out_address;

  // Arena size: reset value or the written register, rounded to granules
  // and clamped to the cap. Never below one granule.
  assign arena_src = rst ? ARENA_RESET : cfg_wdata;
  assign gran_raw  = granules_for(arena_src);
  assign arena_granules_next = (GW'(gran_raw) > GW'(CAP)) ? SZ_W'(CAP) : SZ_W'(gran_raw);

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      arena_granules <= arena_granules_next;
    end
  end

  // Request word into the sequencer
  assign item = '{req_type:       req.req_type,
                  alloc_bytes:    req.alloc_bytes,
                  payload_offset: req.payload_offset};
  assign req.ready = seq_ready;

  // The sequencer may hand over a result when the output slot is empty or
  // is being emptied in this cycle.
  assign ctl.init     = cfg_we;
  assign ctl.out_free = !out_valid || rsp.ready;

  ilha_seq #(.GRANULES(GRANULES)) u_seq (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .arena_granules (arena_granules),
    .in_valid       (req.valid),
    .item           (item),
    .in_ready       (seq_ready),
    .res            (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.done) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (res.done) begin
      out_status  <= res.status;
      out_address <= res.address;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.status  = out_status;
  assign rsp.address = out_address;
endmodule

// ===== design/ilha_ram.sv =====
module ilha_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== design/ilha_alu.sv =====
module ilha_alu #(
  parameter int W = 15
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum
);
  // a + b, or a - b when sub is set
  assign sum = a + (b ^ {W{sub}}) + W'(sub);
endmodule

// ===== design/ilha_seq.sv =====
module ilha_seq #(
  parameter int GRANULES = ilha_pkg::GRANULES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ilha_pkg::ilha_ctl_t              ctl,
  input  logic [$clog2(GRANULES+1)-1:0]    arena_granules,
  input  logic                             in_valid,
  input  ilha_pkg::ilha_item_t             item,
  output logic                             in_ready,
  output ilha_pkg::ilha_res_t              res
);
  import ilha_pkg::*;

  localparam int SZ_W  = $clog2(GRANULES+1);
  localparam int HDR_W = SZ_W + 1;
  localparam int ADR_W = $clog2(GRANULES);
  localparam int CMP_W = (SZ_W > NEED_W) ? SZ_W : NEED_W;
  localparam int OPW   = CMP_W + 1;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_SPLIT = 3'd4;
  localparam logic [2:0] S_CQ    = 3'd5;
  localparam logic [2:0] S_CEV   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]          state, state_next;
  logic [REQ_W-1:0]    op, op_next;
  logic [NEED_W-1:0]   need, need_next;
  logic [TGT_W-1:0]    target, target_next;
  logic [SZ_W-1:0]     p, p_next;
  logic [SZ_W-1:0]     q, q_next;
  logic [HDR_W-1:0]    h, h_next;
  logic [SZ_W-1:0]     rem, rem_next;
  logic [STATUS_W-1:0] st, st_next;
  logic [ADDR_W-1:0]   adr, adr_next;
  logic                done;

  logic             ram_we, ram_re;
  logic [ADR_W-1:0] ram_waddr, ram_raddr;
  logic [HDR_W-1:0] ram_wdata, rd_data;

  logic [OPW-1:0] alu_a, alu_b, alu_sum;
  logic           alu_sub;

  logic [SZ_W-1:0] rd_sz, h_sz;
  logic            rd_alloc, h_alloc;
  logic            p_lt_ag, p_lt_tg, p_eq_tg, fit;

  ilha_ram #(.WIDTH(HDR_W), .DEPTH(GRANULES)) u_hdr (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  ilha_alu #(.W(OPW)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  assign rd_sz    = rd_data[HDR_W-1:1];
  assign rd_alloc = rd_data[0];
  assign h_sz     = h[HDR_W-1:1];
  assign h_alloc  = h[0];
  assign p_lt_ag  = p < arena_granules;
  assign p_lt_tg  = OPW'(p) < OPW'(target);
  assign p_eq_tg  = OPW'(p) == OPW'(target);
  assign fit      = !rd_alloc && (OPW'(rd_sz) >= OPW'(need));

  assign in_ready = (state == S_IDLE);
  assign res      = '{done: done, status: st, address: adr};

  always_comb begin
    state_next  = state;
    op_next     = op;
    need_next   = need;
    target_next = target;
    p_next      = p;
    q_next      = q;
    h_next      = h;
    rem_next    = rem;
    st_next     = st;
    adr_next    = adr;
    done        = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = p[ADR_W-1:0];
    ram_raddr   = p[ADR_W-1:0];
    ram_wdata   = {arena_granules, 1'b0};
    alu_a       = OPW'(p);
    alu_b       = OPW'(rd_sz);
    alu_sub     = 1'b0;

    unique case (state)
      S_INIT: begin
        // one free block over the whole arena
        ram_we     = 1'b1;
        ram_waddr  = '0;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op_next     = item.req_type;
          need_next   = granules_for(item.alloc_bytes);
          target_next = item.payload_offset[OFF_W-1:GRAN_SHIFT];
          p_next      = '0;
          st_next     = ST_DONE;
          adr_next    = '0;
          unique case (item.req_type)
            REQ_ALLOC, REQ_COAL: state_next = S_RD;
            REQ_FREE: begin
              if (item.payload_offset[GRAN_SHIFT-1:0] == PAYLOAD_OFS) begin
                state_next = S_RD;
              end else begin
                st_next    = ST_BADFREE;
                state_next = S_FIN;
              end
            end
            REQ_NONE: state_next = S_FIN;
          endcase
        end
      end
      S_RD: begin
        if (op == REQ_FREE) begin
          if (p_lt_ag && (p_lt_tg || p_eq_tg)) begin
            ram_re     = 1'b1;
            state_next = S_EVAL;
          end else begin
            st_next    = ST_BADFREE;
            state_next = S_FIN;
          end
        end else if (p_lt_ag) begin
          ram_re     = 1'b1;
          state_next = S_EVAL;
        end else begin
          st_next    = (op == REQ_ALLOC) ? ST_NOFIT : ST_DONE;
          state_next = S_FIN;
        end
      end
      S_EVAL: begin
        if (op == REQ_ALLOC) begin
          if (rd_sz == '0) begin
            st_next    = ST_NOFIT;
            state_next = S_FIN;
          end else if (fit) begin
            ram_we     = 1'b1;
            ram_wdata  = {SZ_W'(need), 1'b1};
            alu_a      = OPW'(rd_sz);
            alu_b      = OPW'(need);
            alu_sub    = 1'b1;
            rem_next   = SZ_W'(alu_sum);
            adr_next   = ADDR_W'({p, PAYLOAD_OFS});
            state_next = S_SPLIT;
          end else begin
            p_next     = SZ_W'(alu_sum);
            state_next = S_RD;
          end
        end else if (op == REQ_FREE) begin
          if (p_lt_tg) begin
            if (rd_sz == '0) begin
              st_next    = ST_BADFREE;
              state_next = S_FIN;
            end else begin
              p_next     = SZ_W'(alu_sum);
              state_next = S_RD;
            end
          end else if (rd_alloc) begin
            ram_we     = 1'b1;
            ram_wdata  = {rd_sz, 1'b0};
            state_next = S_FIN;
          end else begin
            st_next    = ST_BADFREE;
            state_next = S_FIN;
          end
        end else begin
          h_next     = rd_data;
          state_next = S_CQ;
        end
      end
      S_SPLIT: begin
        // remainder header after the new block, skipped on an exact fit
        alu_b     = OPW'(need);
        ram_waddr = alu_sum[ADR_W-1:0];
        ram_wdata = {rem, 1'b0};
        if ((rem != '0) && (alu_sum < OPW'(GRANULES))) begin
          ram_we = 1'b1;
        end
        state_next = S_FIN;
      end
      S_CQ: begin
        alu_b     = OPW'(h_sz);
        q_next    = SZ_W'(alu_sum);
        ram_raddr = alu_sum[ADR_W-1:0];
        if ((h_sz == '0) || (alu_sum >= OPW'(arena_granules))) begin
          state_next = S_FIN;
        end else begin
          ram_re     = 1'b1;
          state_next = S_CEV;
        end
      end
      S_CEV: begin
        alu_a = OPW'(h_sz);
        if (!h_alloc && !rd_alloc && (rd_sz != '0)) begin
          ram_we    = 1'b1;
          ram_wdata = {SZ_W'(alu_sum), 1'b0};
          h_next    = {SZ_W'(alu_sum), 1'b0};
        end else begin
          p_next = q;
          h_next = rd_data;
        end
        state_next = S_CQ;
      end
      S_FIN: begin
        if (ctl.out_free) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else if (ctl.init) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
    op     <= op_next;
    need   <= need_next;
    target <= target_next;
    p      <= p_next;
    q      <= q_next;
    h      <= h_next;
    rem    <= rem_next;
    st     <= st_next;
    adr    <= adr_next;
  end
endmodule

// ===== design/ilha_checker.sv =====
`include "assert_macros.svh"

module ilha_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_we,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [ilha_pkg::STATUS_W-1:0] rsp_status,
  input logic [ilha_pkg::ADDR_W-1:0]   rsp_address
);
  import ilha_pkg::*;

  // one request word at a time
  `ILHA_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")
  // arena rebuild blocks the request side
  `ILHA_ASSERT_NXT(a_busy_after_cfg, cfg_we, !req_ready, "ready during arena rebuild")
  `ILHA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_address), "stalled result word changed")
  `ILHA_ASSERT_IMP(a_fail_zero_addr, rsp_valid && rsp_status != ST_DONE, rsp_address == '0, "failed request with nonzero address")
  `ILHA_ASSERT_IMP(a_addr_align, rsp_valid && rsp_address != '0, rsp_address[GRAN_SHIFT-1:0] == PAYLOAD_OFS, "payload address off granule")
endmodule

bind implicit_list_heap_allocator ilha_checker u_ilha_checker (
  .clk         (clk),
  .rst         (rst),
  .cfg_we      (cfg_we),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_status  (rsp.status),
  .rsp_address (rsp.address)
);
